// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent property check on a clock, disabled while reset is low.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Expression that must never be true.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  `ASSERT_PROP(lbl, clk, rstn, !(expr))

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== rtl/mkcp_pkg.sv =====
// Types, codes and reset constants of the media key click/press classifier.
// No dependencies.
`default_nettype none

package mkcp_pkg;

  localparam int unsigned CodeW   = 16;
  localparam int unsigned NumKeys = 6;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [2:0]       key_idx_t;

  typedef enum logic [1:0] {
    FUNC_DOWN = 2'd0,
    FUNC_UP   = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_RSVD = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ACT_PRESSED  = 2'd0,
    ACT_RELEASED = 2'd1,
    ACT_CLICKED  = 2'd2
  } action_e;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VOL_UP     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VOL_DOWN   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PLAY       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STOP       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FORWARD    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_REWIND     = 3'd6;

  // Key slots
  localparam key_idx_t KEY_VOL_UP   = 3'd0;
  localparam key_idx_t KEY_VOL_DOWN = 3'd1;
  localparam key_idx_t KEY_PLAY     = 3'd2;
  localparam key_idx_t KEY_STOP     = 3'd3;
  localparam key_idx_t KEY_FORWARD  = 3'd4;
  localparam key_idx_t KEY_REWIND   = 3'd5;

  // Reset values
  localparam code_t RST_HOLD_TICKS = 16'd600;
  localparam code_t RST_VOL_UP     = 16'd163;
  localparam code_t RST_VOL_DOWN   = 16'd162;
  localparam code_t RST_PLAY       = 16'd182;
  localparam code_t RST_STOP       = 16'd183;
  localparam code_t RST_FORWARD    = 16'd184;
  localparam code_t RST_REWIND     = 16'd185;
  localparam code_t CODE_NONE      = 16'h0000;
  localparam code_t COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    func_e func;
    code_t scan_code;
  } in_t;

  typedef struct packed {
    logic     publish_valid;
    logic     channel;
    key_idx_t key_index;
    action_e  action;
    logic     blocked;
  } out_t;

  typedef struct packed {
    code_t                   hold_ticks;
    logic [NumKeys-1:0][CodeW-1:0] key_codes;
  } cfg_t;

  // Item stage to classifier: event and step strobe
  typedef struct packed {
    logic advance;
    in_t  item;
  } step_t;

  // Classifier to output buffer
  typedef struct packed {
    logic has_result;
    out_t result;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/mkcp_classify.sv =====
// Hold/click state of the classifier and the per-event decision logic.
// Depends on mkcp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mkcp_classify import mkcp_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  cfg_t  cfg_i,
  input  step_t step_i,
  output res_t  res_o
);

  logic  timer_running_q, timer_running_d;
  logic  press_sent_q, press_sent_d;
  logic  release_done_q, release_done_d;
  code_t held_code_q, held_code_d;
  code_t tick_count_q, tick_count_d;

  code_t    scan;
  code_t    pub_code;
  logic     known;
  key_idx_t known_idx;
  logic     pub_found;
  key_idx_t pub_idx;
  logic     scan_deferred;
  logic     held_deferred;
  code_t    count_inc;
  logic     do_publish;
  action_e  pub_action;

  assign scan = step_i.item.scan_code;
  // Ticks publish for the held key, key events for their own code
  assign pub_code = (step_i.item.func == FUNC_TICK) ? held_code_q : scan;

  // First matching slot wins
  always_comb begin
    known     = 1'b0;
    known_idx = KEY_VOL_UP;
    pub_found = 1'b0;
    pub_idx   = KEY_VOL_UP;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (cfg_i.key_codes[i] == scan) begin
        known     = 1'b1;
        known_idx = key_idx_t'(i);
      end
      if (cfg_i.key_codes[i] == pub_code) begin
        pub_found = 1'b1;
        pub_idx   = key_idx_t'(i);
      end
    end
  end

  assign scan_deferred = (scan == cfg_i.key_codes[KEY_FORWARD]) ||
                         (scan == cfg_i.key_codes[KEY_REWIND]);
  assign held_deferred = (held_code_q == cfg_i.key_codes[KEY_FORWARD]) ||
                         (held_code_q == cfg_i.key_codes[KEY_REWIND]);

  assign count_inc = (tick_count_q == COUNT_MAX) ? tick_count_q : tick_count_q + 16'd1;

  always_comb begin
    timer_running_d = timer_running_q;
    press_sent_d    = press_sent_q;
    release_done_d  = release_done_q;
    held_code_d     = held_code_q;
    tick_count_d    = tick_count_q;
    do_publish      = 1'b0;
    pub_action      = ACT_CLICKED;
    res_o           = '0;

    unique case (step_i.item.func)
      FUNC_DOWN: begin
        res_o.has_result = 1'b1;
        if (known && !timer_running_q && release_done_q) begin
          do_publish      = !scan_deferred;
          pub_action      = ACT_CLICKED;
          timer_running_d = 1'b1;
          tick_count_d    = '0;
          held_code_d     = scan;
          press_sent_d    = 1'b0;
          release_done_d  = 1'b0;
          res_o.result.blocked = 1'b1;
        end
      end
      FUNC_UP: begin
        res_o.has_result = 1'b1;
        if (known && held_code_q == scan) begin
          if (!press_sent_q) begin
            do_publish      = held_deferred;
            pub_action      = ACT_CLICKED;
            timer_running_d = 1'b0;
          end else begin
            do_publish   = 1'b1;
            pub_action   = ACT_RELEASED;
            press_sent_d = 1'b0;
          end
          release_done_d = 1'b1;
          held_code_d    = CODE_NONE;
          res_o.result.blocked = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (timer_running_q) begin
          tick_count_d = count_inc;
          if (count_inc >= cfg_i.hold_ticks) begin
            do_publish       = 1'b1;
            pub_action       = ACT_PRESSED;
            press_sent_d     = 1'b1;
            timer_running_d  = 1'b0;
            res_o.has_result = 1'b1;
          end
        end
      end
      FUNC_RSVD: begin
        res_o.has_result = 1'b0;
      end
    endcase

    // Code rewritten away from every slot: state moves, nothing published
    if (do_publish && pub_found) begin
      res_o.result.publish_valid = 1'b1;
      res_o.result.channel       = !((pub_code == cfg_i.key_codes[KEY_VOL_UP]) ||
                                     (pub_code == cfg_i.key_codes[KEY_VOL_DOWN]));
      res_o.result.key_index     = pub_idx;
      res_o.result.action        = pub_action;
    end

    // known_idx only qualifies the match; slot comes from the publish lookup
    if (!known) begin
      res_o.result.blocked = 1'b0;
    end else if (known_idx > KEY_REWIND) begin
      res_o.result.blocked = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_running_q <= 1'b0;
      press_sent_q    <= 1'b0;
      release_done_q  <= 1'b1;
      held_code_q     <= CODE_NONE;
      tick_count_q    <= '0;
    end else if (step_i.advance) begin
      timer_running_q <= timer_running_d;
      press_sent_q    <= press_sent_d;
      release_done_q  <= release_done_d;
      held_code_q     <= held_code_d;
      tick_count_q    <= tick_count_d;
    end
  end

  // Idle: no timer, no press pending
  `ASSERT_PROP(a_idle_clean, clk_i, rst_ni,
               release_done_q |-> (!timer_running_q && !press_sent_q))
  // Holding: either timing or pressed, never both
  `ASSERT_PROP(a_hold_phase, clk_i, rst_ni,
               !release_done_q |-> (timer_running_q ^ press_sent_q))
  `ASSERT_PROP(a_idle_no_code, clk_i, rst_ni,
               release_done_q |-> (held_code_q == CODE_NONE))

endmodule

`default_nettype wire

// ===== rtl/media_key_click_press_classifier_core.sv =====
// Top level of the media key click/press classifier: configuration registers,
// item register, classifier and two-entry result buffer.
// Depends on mkcp_pkg, mkcp_classify and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one transaction per cycle on the input channel while the result skid
// is free: key down, key up or a 1 ms tick. Every key event yields one result
// transaction (blocked tells whether the event was consumed, publish_valid
// whether a click, press or release was published); a tick yields one only
// when it fires a press, and reserved event kinds yield none. The event is
// registered, classified against the held-key state in one pass, and the
// result lands in a registered output with a one-entry skid behind it, so
// input keeps flowing while a result waits. The classifier updates its state
// in the same pass, which sets the sustained rate of one transaction per cycle.
// Configuration writes (index 0 hold_ticks, 1..6 the key scan codes vol up,
// vol down, play, stop, forward, rewind) take effect at once and belong only
// to idle periods; unused indexes are ignored.
module media_key_click_press_classifier_core import mkcp_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [CfgIdxW-1:0] cfg_idx_i,
  input  wire  [CodeW-1:0]   cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output out_t               out_data_o
);

  cfg_t  cfg_q;

  logic  in_valid_q;
  in_t   in_q;
  logic  advance;

  logic  out_valid_q, out_valid_d;
  out_t  out_q, out_d;
  logic  skid_valid_q, skid_valid_d;
  out_t  skid_q, skid_d;
  logic  out_take;

  step_t step;
  res_t  res;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks                <= RST_HOLD_TICKS;
      cfg_q.key_codes[KEY_VOL_UP]     <= RST_VOL_UP;
      cfg_q.key_codes[KEY_VOL_DOWN]   <= RST_VOL_DOWN;
      cfg_q.key_codes[KEY_PLAY]       <= RST_PLAY;
      cfg_q.key_codes[KEY_STOP]       <= RST_STOP;
      cfg_q.key_codes[KEY_FORWARD]    <= RST_FORWARD;
      cfg_q.key_codes[KEY_REWIND]     <= RST_REWIND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOLD_TICKS: cfg_q.hold_ticks              <= cfg_wdata_i;
        REG_VOL_UP:     cfg_q.key_codes[KEY_VOL_UP]   <= cfg_wdata_i;
        REG_VOL_DOWN:   cfg_q.key_codes[KEY_VOL_DOWN] <= cfg_wdata_i;
        REG_PLAY:       cfg_q.key_codes[KEY_PLAY]     <= cfg_wdata_i;
        REG_STOP:       cfg_q.key_codes[KEY_STOP]     <= cfg_wdata_i;
        REG_FORWARD:    cfg_q.key_codes[KEY_FORWARD]  <= cfg_wdata_i;
        REG_REWIND:     cfg_q.key_codes[KEY_REWIND]   <= cfg_wdata_i;
        default:        cfg_q <= cfg_q;  // index past the register list
      endcase
    end
  end

  // ---------------- item register ----------------
  // The held item moves on whenever the skid is free: worst case the output
  // is full and the result drops into the skid.
  assign advance    = in_valid_q && !skid_valid_q;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // ---------------- classifier ----------------
  assign step.advance = advance;
  assign step.item    = in_q;

  mkcp_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (step),
    .res_o  (res)
  );

  // ---------------- result register and skid ----------------
  assign out_take = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // no new result can arrive while the skid is occupied
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (advance && res.has_result) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        out_d       = res.result;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res.result;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Skid only ever holds the younger of two pending results
  `ASSERT_PROP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  // Skid fills only when the output was stalled
  `ASSERT_PROP(a_skid_fill, clk_i, rst_ni,
               $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
  `ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, skid_valid_q && advance)

endmodule

`default_nettype wire

// ===== tb/tb_media_key_click_press_classifier_core.sv =====
// Testbench of media_key_click_press_classifier_core: a directed table, one
// long hold and random key sequences, checked against an in-bench model and literal table results.
// Depends on mkcp_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_media_key_click_press_classifier_core;
  import mkcp_pkg::*;

  // Run limits. QUIET_CYCLES of spare waiting cover an event in flight that
  // produces nothing.
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned QUIET_CYCLES    = 4;
  localparam int unsigned END_CYCLES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 425;
  localparam int unsigned ITEMS_PER_SET   = 110;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned LONG_TICKS      = 40;

  localparam code_t RESET_CODES [NumKeys] = '{
    RST_VOL_UP, RST_VOL_DOWN, RST_PLAY, RST_STOP, RST_FORWARD, RST_REWIND
  };

  // Common result shapes: passed on untouched, or consumed with nothing published
  localparam out_t R_QUIET = '0;
  localparam out_t R_TAKEN = '{1'b0, 1'b0, KEY_VOL_UP, ACT_PRESSED, 1'b1};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    code_t              reg_val;
    in_t                item;
    bit                 use_lit;
    out_t               lit;
  } row_t;

  // Directed table. Literal results are given where they follow directly from
  // reset values, extremes and the pass-through cases; the rest use the model.
  localparam int unsigned NUM_ROWS = 33;
  row_t dir_rows [NUM_ROWS] = '{
    // unknown codes at both extremes, idle tick, reserved event kind
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, 16'h0000}, 1'b1, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, 16'hFFFF}, 1'b1, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_TICK, 16'hFFFF}, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_RSVD, RST_VOL_UP}, 1'b0, R_QUIET},
    // click at once, then a busy key-down and a stray key-up
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, RST_VOL_UP}, 1'b1,
      '{1'b1, 1'b0, KEY_VOL_UP, ACT_CLICKED, 1'b1}},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, RST_PLAY}, 1'b1, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_PLAY}, 1'b1, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_VOL_UP}, 1'b1, R_TAKEN},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_VOL_UP}, 1'b1, R_QUIET},
    // forward: click held back until key-up
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, RST_FORWARD}, 1'b1, R_TAKEN},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_FORWARD}, 1'b1,
      '{1'b1, 1'b1, KEY_FORWARD, ACT_CLICKED, 1'b1}},
    // zero hold time fires on the first tick
    '{ROW_CFG, REG_HOLD_TICKS, 16'd0, '0, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, RST_REWIND}, 1'b1, R_TAKEN},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_TICK, 16'h0000}, 1'b1,
      '{1'b1, 1'b1, KEY_REWIND, ACT_PRESSED, 1'b0}},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_TICK, 16'h0000}, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, RST_VOL_DOWN}, 1'b1, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_REWIND}, 1'b1,
      '{1'b1, 1'b1, KEY_REWIND, ACT_RELEASED, 1'b1}},
    // hold time lowered while the key is down
    '{ROW_CFG, REG_HOLD_TICKS, 16'd5, '0, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, RST_VOL_DOWN}, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_TICK, 16'h5A5A}, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_TICK, 16'hA5A5}, 1'b0, R_QUIET},
    '{ROW_CFG, REG_HOLD_TICKS, 16'd2, '0, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_TICK, 16'h0000}, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_VOL_DOWN}, 1'b0, R_QUIET},
    // held code drops out of the key table before its press
    '{ROW_CFG, REG_HOLD_TICKS, 16'd1, '0, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, RST_STOP}, 1'b0, R_QUIET},
    '{ROW_CFG, REG_STOP, 16'h1234, '0, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_TICK, 16'h0000}, 1'b1, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_STOP}, 1'b1, R_QUIET},
    '{ROW_CFG, REG_STOP, RST_STOP, '0, 1'b0, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_UP, RST_STOP}, 1'b1,
      '{1'b1, 1'b1, KEY_STOP, ACT_RELEASED, 1'b1}},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_DOWN, 16'h1234}, 1'b1, R_QUIET},
    '{ROW_ITEM, REG_HOLD_TICKS, 16'd0, '{FUNC_RSVD, 16'hFFFF}, 1'b0, R_QUIET}
  };

  // DUT signals; the inputs are at known values from time zero
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CodeW-1:0]   cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_t                in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;

  // Idle pressure of the current phase, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned cycle_cnt  = 0;
  int unsigned mismatches = 0;
  out_t        pending_results [$];

  media_key_click_press_classifier_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Classifier model: its own copy of the registers and held-key state
  // ---------------------------------------------------------------------
  code_t hold_limit = RST_HOLD_TICKS;
  code_t key_code_tab [NumKeys] = RESET_CODES;
  bit    timer_on     = 1'b0;
  bit    press_out    = 1'b0;
  bit    release_seen = 1'b1;
  code_t held_code    = CODE_NONE;
  code_t tick_cnt     = '0;

  // First matching slot wins when codes are duplicated
  function automatic int slot_of(code_t c);
    for (int i = 0; i < NumKeys; i++) begin
      if (key_code_tab[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic bit is_deferred(code_t c);
    return (c == key_code_tab[KEY_FORWARD]) || (c == key_code_tab[KEY_REWIND]);
  endfunction

  // Fills the published action; a code missing from the table publishes nothing
  function automatic void put_action(inout out_t r, input code_t c, input action_e a);
    int k;
    k = slot_of(c);
    if (k >= 0) begin
      r.publish_valid = 1'b1;
      r.channel       = !((c == key_code_tab[KEY_VOL_UP]) ||
                          (c == key_code_tab[KEY_VOL_DOWN]));
      r.key_index     = key_idx_t'(k);
      r.action        = a;
    end
  endfunction

  // Advances the model by one event; returns 1 when the event gives a result
  function automatic bit classify_event(input in_t ev, output out_t r);
    bit known;
    bit has;
    r     = '0;
    has   = 1'b0;
    known = slot_of(ev.scan_code) >= 0;
    case (ev.func)
      FUNC_DOWN: begin
        if (known && !timer_on && release_seen) begin
          if (!is_deferred(ev.scan_code)) put_action(r, ev.scan_code, ACT_CLICKED);
          timer_on     = 1'b1;
          tick_cnt     = '0;
          held_code    = ev.scan_code;
          press_out    = 1'b0;
          release_seen = 1'b0;
          r.blocked    = 1'b1;
        end
        has = 1'b1;
      end
      FUNC_UP: begin
        if (known && held_code == ev.scan_code) begin
          if (!press_out) begin
            if (is_deferred(held_code)) put_action(r, held_code, ACT_CLICKED);
            timer_on = 1'b0;
          end else begin
            put_action(r, ev.scan_code, ACT_RELEASED);
            press_out = 1'b0;
          end
          release_seen = 1'b1;
          held_code    = CODE_NONE;
          r.blocked    = 1'b1;
        end
        has = 1'b1;
      end
      FUNC_TICK: begin
        if (timer_on) begin
          if (tick_cnt != COUNT_MAX) tick_cnt++;
          // hold time 0 behaves as 1 since the count is already at least 1
          if (tick_cnt >= hold_limit) begin
            put_action(r, held_code, ACT_PRESSED);
            press_out = 1'b1;
            timer_on  = 1'b0;
            has       = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return has;
  endfunction

  function automatic in_t make_event(func_e f, code_t s);
    in_t ev;
    ev.func      = f;
    ev.scan_code = s;
    return ev;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers. Every task is entered and left right after a falling edge.
  // ---------------------------------------------------------------------

  // Offers one transaction, holds it until accepted, and records what the
  // model expects for it at the accepting edge. A literal, when given,
  // replaces the model's result.
  task automatic send_item(input in_t ev, input bit use_lit = 1'b0,
                           input out_t lit = '0);
    out_t pred;
    bit   has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    has = classify_event(ev, pred);
    if (use_lit) pending_results.push_back(lit);
    else if (has) pending_results.push_back(pred);
    @(negedge clk);
  endtask

  // Waits until every result is out, then lets an in-flight event settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input code_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == REG_HOLD_TICKS) hold_limit = val;
    else if (idx <= REG_REWIND) key_code_tab[idx - REG_VOL_UP] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Loads a full register set. Hold times stay short so presses happen often.
  task automatic pick_setting(input int unsigned kind);
    code_t c;
    for (int i = 0; i < NumKeys; i++) begin
      case (kind)
        0:       c = RESET_CODES[i];
        1:       c = code_t'($urandom_range(7));     // many duplicates
        2:       c = code_t'($urandom);
        default: begin
          case ($urandom_range(2))
            0:       c = 16'h0000;
            1:       c = 16'hFFFF;
            default: c = code_t'($urandom);
          endcase
        end
      endcase
      write_reg(CfgIdxW'(REG_VOL_UP + i), c);
    end
    case (kind)
      0:       write_reg(REG_HOLD_TICKS, code_t'($urandom_range(4, 1)));
      1:       write_reg(REG_HOLD_TICKS, code_t'($urandom_range(1)));
      2:       write_reg(REG_HOLD_TICKS, code_t'($urandom_range(6, 2)));
      default: write_reg(REG_HOLD_TICKS, code_t'($urandom_range(3, 1)));
    endcase
  endtask

  // Any event kind, either a table code or a random one
  task automatic send_noise();
    code_t s;
    if ($urandom_range(2) == 0) s = key_code_tab[$urandom_range(NumKeys - 1)];
    else s = code_t'($urandom);
    send_item(make_event(func_e'($urandom_range(3)), s));
  endtask

  // Closes an open hold so that a register change cannot strand it
  task automatic close_hold(inout int unsigned cnt);
    if (!release_seen) begin
      send_item(make_event(FUNC_UP, held_code));
      cnt++;
    end
  endtask

  // One key stroke: down, a tick run around the hold time with some noise,
  // and mostly a key-up. A missing key-up is closed by the next stroke.
  task automatic play_stroke(inout int unsigned cnt);
    code_t       c;
    int unsigned n;
    int unsigned lim;
    close_hold(cnt);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) send_noise();
    end
    c   = key_code_tab[$urandom_range(NumKeys - 1)];
    lim = (hold_limit == 0) ? 1 : hold_limit;
    n   = $urandom_range(lim + 2);
    send_item(make_event(FUNC_DOWN, c));
    cnt++;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        send_noise();
        cnt++;
      end
      send_item(make_event(FUNC_TICK, code_t'($urandom)));
      cnt++;
    end
    if ($urandom_range(9) != 0) begin
      send_item(make_event(FUNC_UP, c));
      cnt++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stall, and the scoreboard check per transaction
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with none expected: pv=%0b ch=%0b key=%0d act=%0d blk=%0b",
                   $realtime, out_data.publish_valid, out_data.channel,
                   out_data.key_index, out_data.action, out_data.blocked);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.publish_valid !== want.publish_valid ||
            out_data.channel       !== want.channel ||
            out_data.key_index     !== want.key_index ||
            out_data.action        !== want.action ||
            out_data.blocked       !== want.blocked) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch: exp pv=%0b ch=%0b key=%0d act=%0d blk=%0b,",
                     $realtime, want.publish_valid, want.channel, want.key_index,
                     want.action, want.blocked,
                     " got pv=%0b ch=%0b key=%0d act=%0d blk=%0b",
                     out_data.publish_valid, out_data.channel,
                     out_data.key_index, out_data.action, out_data.blocked);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned since_set;
    int unsigned set_no;
    int unsigned dummy;
    set_no = 0;
    dummy  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, no idling; register rows wait for the block to go quiet
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].use_lit, dir_rows[r].lit);
      end
    end

    // Longest hold time: a short tick run stays far below it, so the key-up
    // ends the hold without a press
    wait_quiet();
    write_reg(REG_HOLD_TICKS, COUNT_MAX);
    send_item(make_event(FUNC_DOWN, RST_PLAY));
    repeat (LONG_TICKS) send_item(make_event(FUNC_TICK, code_t'($urandom)));
    send_item(make_event(FUNC_UP, RST_PLAY));

    // Random strokes under four idle patterns, register set redrawn every so often
    for (int ph = 0; ph < 4; ph++) begin
      close_hold(dummy);
      wait_quiet();
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 62; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 6;  stall_pct = 6;  end
      endcase
      pick_setting(set_no % 4);
      set_no++;
      sent      = 0;
      since_set = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (since_set >= ITEMS_PER_SET) begin
          close_hold(sent);
          wait_quiet();
          pick_setting(set_no % 4);
          set_no++;
          since_set = 0;
        end
        since_set -= sent;
        play_stroke(sent);
        since_set += sent;
      end
    end

    close_hold(dummy);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
